// File: rtl/wmmaf_pkg.sv
package wmmaf_pkg;

  localparam int DATA_W    = 16;
  localparam int CFG_W     = 16;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int GAIN_FRAC = 12;

  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_MEDIAN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_THR  = 3'd4;

  localparam logic [DATA_W-1:0] RST_CAL_GAIN   = 16'd4096;
  localparam logic [DATA_W-1:0] RST_CAL_OFFSET = 16'd0;
  localparam logic [LEN_W-1:0]  RST_WINDOW_LEN = 5'd10;
  localparam logic              RST_USE_MEDIAN = 1'b0;
  localparam logic [DATA_W-1:0] RST_ALARM_THR  = 16'd400;

endpackage

// File: rtl/windowed_median_mean_alarm_filter.sv
// Windowed median / mean filter with threshold alarm, one channel.
// Input channel (in_valid/in_ready, in_raw_sample): one converter reading per
// request. The reading is calibrated as (raw * gain) >> 12 + offset, clipped
// to 0..65535 and written into a ring of window_len entries, clamped to 1..16.
// Result channel (out_valid/out_ready): filtered value (floor mean or upper
// median of the filled entries), alarm flag and entry count, one per request.
// Configuration (cfg_we/cfg_index/cfg_wdata): single-cycle register writes.
// A microcoded sequencer steps a small datapath with one ring read port:
//   mean:   the n filled entries are read and summed one at a time, then a
//           21-step serial divide by n gives the floor mean,
//   median: k candidates ranked before the median is found (k <= n), one
//           pass over the filled entries per candidate.
// One item is in flight at a time; in_ready rises again with out_valid, when
// the result is loaded into the output register. A stalled receiver holds the
// result register and the sequencer waits in its last step until it drains.
// Reset (synchronous, rst_n low) restores register defaults, empties the
// window, drops out_valid and returns the sequencer to idle.
module windowed_median_mean_alarm_filter #(
  parameter int SAMPLE_BITS  = wmmaf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [SAMPLE_BITS-1:0]             in_raw_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [wmmaf_pkg::DATA_W-1:0]       out_filtered_value,
  output logic                               out_alarm,
  output logic [wmmaf_pkg::LEN_W-1:0]        out_entries_used,
  input  logic                               cfg_we,
  input  logic [wmmaf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wmmaf_pkg::CFG_W-1:0]        cfg_wdata
);
  import wmmaf_pkg::*;

  localparam int WINDOW_DEPTH = WINDOW_DEPTH_DEF;
  localparam int SLOT_W   = $clog2(WINDOW_DEPTH);
  localparam int PROD_W   = SAMPLE_BITS + DATA_W;
  localparam int SCALED_W = PROD_W - GAIN_FRAC;
  localparam int CALC_W   = SCALED_W + 2;
  localparam int SUM_W    = DATA_W + LEN_W;
  localparam int CNT_W    = $clog2(SUM_W + 1);
  localparam int PC_W     = 4;
  localparam int OP_W     = 4;

  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_ACCEPT   = 4'd1;
  localparam logic [OP_W-1:0] OP_CAL      = 4'd2;
  localparam logic [OP_W-1:0] OP_READ_J   = 4'd3;
  localparam logic [OP_W-1:0] OP_ACC      = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV_INIT = 4'd5;
  localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd6;
  localparam logic [OP_W-1:0] OP_DIV_DONE = 4'd7;
  localparam logic [OP_W-1:0] OP_READ_I   = 4'd8;
  localparam logic [OP_W-1:0] OP_PIVOT    = 4'd9;
  localparam logic [OP_W-1:0] OP_RANK     = 4'd10;
  localparam logic [OP_W-1:0] OP_CHECK    = 4'd11;
  localparam logic [OP_W-1:0] OP_EMIT     = 4'd12;

  localparam logic [1:0] W_NONE = 2'd0;
  localparam logic [1:0] W_IN   = 2'd1;
  localparam logic [1:0] W_OUT  = 2'd2;

  localparam logic [2:0] C_NEVER     = 3'd0;
  localparam logic [2:0] C_ALWAYS    = 3'd1;
  localparam logic [2:0] C_MEDIAN    = 3'd2;
  localparam logic [2:0] C_MORE_J    = 3'd3;
  localparam logic [2:0] C_DIV_MORE  = 3'd4;
  localparam logic [2:0] C_NOT_FOUND = 3'd5;

  localparam logic [PC_W-1:0] S_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] S_CAL      = 4'd1;
  localparam logic [PC_W-1:0] S_SUM_RD   = 4'd2;
  localparam logic [PC_W-1:0] S_SUM_ACC  = 4'd3;
  localparam logic [PC_W-1:0] S_DIV_INIT = 4'd4;
  localparam logic [PC_W-1:0] S_DIV_STEP = 4'd5;
  localparam logic [PC_W-1:0] S_DIV_DONE = 4'd6;
  localparam logic [PC_W-1:0] S_MED_RDI  = 4'd7;
  localparam logic [PC_W-1:0] S_MED_PIV  = 4'd8;
  localparam logic [PC_W-1:0] S_MED_RDJ  = 4'd9;
  localparam logic [PC_W-1:0] S_MED_CMP  = 4'd10;
  localparam logic [PC_W-1:0] S_MED_CHK  = 4'd11;
  localparam logic [PC_W-1:0] S_EMIT     = 4'd12;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0]      wait_k;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      S_IDLE:     w = '{OP_ACCEPT,   W_IN,   C_NEVER,     S_IDLE};
      S_CAL:      w = '{OP_CAL,      W_NONE, C_MEDIAN,    S_MED_RDI};
      S_SUM_RD:   w = '{OP_READ_J,   W_NONE, C_NEVER,     S_IDLE};
      S_SUM_ACC:  w = '{OP_ACC,      W_NONE, C_MORE_J,    S_SUM_RD};
      S_DIV_INIT: w = '{OP_DIV_INIT, W_NONE, C_NEVER,     S_IDLE};
      S_DIV_STEP: w = '{OP_DIV_STEP, W_NONE, C_DIV_MORE,  S_DIV_STEP};
      S_DIV_DONE: w = '{OP_DIV_DONE, W_NONE, C_ALWAYS,    S_EMIT};
      S_MED_RDI:  w = '{OP_READ_I,   W_NONE, C_NEVER,     S_IDLE};
      S_MED_PIV:  w = '{OP_PIVOT,    W_NONE, C_NEVER,     S_IDLE};
      S_MED_RDJ:  w = '{OP_READ_J,   W_NONE, C_NEVER,     S_IDLE};
      S_MED_CMP:  w = '{OP_RANK,     W_NONE, C_MORE_J,    S_MED_RDJ};
      S_MED_CHK:  w = '{OP_CHECK,    W_NONE, C_NOT_FOUND, S_MED_RDI};
      S_EMIT:     w = '{OP_EMIT,     W_OUT,  C_ALWAYS,    S_IDLE};
      default:    w = '{OP_NONE,     W_NONE, C_ALWAYS,    S_IDLE};
    endcase
    return w;
  endfunction

  logic [DATA_W-1:0]        cfg_gain_r;
  logic signed [DATA_W-1:0] cfg_offset_r;
  logic [LEN_W-1:0]         cfg_wlen_r;
  logic                     cfg_median_r;
  logic [DATA_W-1:0]        cfg_thr_r;

  logic [DATA_W-1:0] ring [WINDOW_DEPTH];

  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [SLOT_W-1:0] write_slot_r;
  logic [LEN_W-1:0]  fill_r;
  logic [SLOT_W-1:0] i_r, j_r;
  logic [LEN_W-1:0]  rank_r;
  logic [DATA_W-1:0] pivot_r;
  logic [DATA_W-1:0] rdata_r;
  logic [SUM_W-1:0]  acc_r;
  logic [LEN_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PROD_W-1:0] prod_r;
  logic [DATA_W-1:0] result_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_alarm_r;
  logic [LEN_W-1:0]  out_used_r;

  ctrl_t             cw;
  logic              hold;
  logic              go;
  logic              jump;
  logic [LEN_W-1:0]  len;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [LEN_W-1:0]  fill_next;
  logic [SCALED_W-1:0]      scaled;
  logic signed [CALC_W-1:0] cal_sum;
  logic [DATA_W-1:0]        cal_val;
  logic [SLOT_W-1:0] rd_addr;
  logic [LEN_W:0]    trial;
  logic [LEN_W:0]    diff;
  logic              more_j;
  logic              found;

  assign cw        = ucode(pc_r);
  assign in_ready  = (pc_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_filtered_value = out_value_r;
  assign out_alarm          = out_alarm_r;
  assign out_entries_used   = out_used_r;

  always_comb begin
    hold = ((cw.wait_k == W_IN) && !in_valid) ||
           ((cw.wait_k == W_OUT) && out_valid_r && !out_ready);
    go   = !hold;
  end

  always_comb begin
    if (cfg_wlen_r == '0) begin
      len = LEN_W'(1);
    end else if (int'(cfg_wlen_r) > WINDOW_DEPTH) begin
      len = LEN_W'(WINDOW_DEPTH);
    end else begin
      len = cfg_wlen_r;
    end
    slot = (32'(write_slot_r) < 32'(len)) ? write_slot_r : '0;
    slot_next = (32'(slot) + 32'd1 >= 32'(len)) ? '0 : SLOT_W'(32'(slot) + 32'd1);
    if (fill_r > len) begin
      fill_next = len;
    end else if (fill_r < len) begin
      fill_next = fill_r + LEN_W'(1);
    end else begin
      fill_next = fill_r;
    end
  end

  always_comb begin
    scaled  = prod_r[PROD_W-1:GAIN_FRAC];
    cal_sum = $signed({2'b00, scaled}) + CALC_W'(cfg_offset_r);
    if (cal_sum < 0) begin
      cal_val = '0;
    end else if (cal_sum > $signed(CALC_W'(32'hFFFF))) begin
      cal_val = '1;
    end else begin
      cal_val = cal_sum[DATA_W-1:0];
    end
  end

  always_comb begin
    trial  = {rem_r, acc_r[SUM_W-1]};
    diff   = trial - {1'b0, fill_r};
    more_j = (32'(j_r) + 32'd1) < 32'(fill_r);
    found  = (rank_r == (fill_r >> 1));
    rd_addr = (cw.op == OP_READ_I) ? i_r : j_r;
  end

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:    jump = 1'b1;
      C_MEDIAN:    jump = cfg_median_r;
      C_MORE_J:    jump = more_j;
      C_DIV_MORE:  jump = (cnt_r != CNT_W'(1));
      C_NOT_FOUND: jump = !found && ((32'(i_r) + 32'd1) < 32'(fill_r));
      default:     jump = 1'b0;
    endcase
    if (hold) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_gain_r   <= RST_CAL_GAIN;
      cfg_offset_r <= RST_CAL_OFFSET;
      cfg_wlen_r   <= RST_WINDOW_LEN;
      cfg_median_r <= RST_USE_MEDIAN;
      cfg_thr_r    <= RST_ALARM_THR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAL_GAIN:   cfg_gain_r   <= cfg_wdata;
        CFG_CAL_OFFSET: cfg_offset_r <= cfg_wdata;
        CFG_WINDOW_LEN: cfg_wlen_r   <= cfg_wdata[LEN_W-1:0];
        CFG_USE_MEDIAN: cfg_median_r <= cfg_wdata[0];
        CFG_ALARM_THR:  cfg_thr_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (go && (cw.op == OP_CAL)) begin
      ring[slot] <= cal_val;
    end
    rdata_r <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= S_IDLE;
      write_slot_r <= '0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (go && (cw.op == OP_EMIT)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (go && (cw.op == OP_CAL)) begin
        write_slot_r <= slot_next;
        fill_r       <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      unique case (cw.op)
        OP_ACCEPT: begin
          prod_r <= PROD_W'(in_raw_sample) * PROD_W'(cfg_gain_r);
        end
        OP_CAL: begin
          i_r   <= '0;
          j_r   <= '0;
          acc_r <= '0;
        end
        OP_ACC: begin
          acc_r <= acc_r + SUM_W'(rdata_r);
          j_r   <= j_r + SLOT_W'(1);
        end
        OP_DIV_INIT: begin
          rem_r <= '0;
          cnt_r <= CNT_W'(SUM_W);
        end
        OP_DIV_STEP: begin
          if (!diff[LEN_W]) begin
            rem_r <= diff[LEN_W-1:0];
          end else begin
            rem_r <= trial[LEN_W-1:0];
          end
          acc_r <= {acc_r[SUM_W-2:0], !diff[LEN_W]};
          cnt_r <= cnt_r - CNT_W'(1);
        end
        OP_DIV_DONE: begin
          result_r <= acc_r[DATA_W-1:0];
        end
        OP_PIVOT: begin
          pivot_r <= rdata_r;
          j_r     <= '0;
          rank_r  <= '0;
        end
        OP_RANK: begin
          if ((rdata_r < pivot_r) || ((rdata_r == pivot_r) && (j_r < i_r))) begin
            rank_r <= rank_r + LEN_W'(1);
          end
          j_r <= j_r + SLOT_W'(1);
        end
        OP_CHECK: begin
          result_r <= pivot_r;
          i_r      <= i_r + SLOT_W'(1);
        end
        OP_EMIT: begin
          out_value_r <= result_r;
          out_alarm_r <= (result_r >= cfg_thr_r);
          out_used_r  <= fill_r;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/wmmaf_checker.sv
module wmmaf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [wmmaf_pkg::DATA_W-1:0]  out_filtered_value,
  input logic                          out_alarm,
  input logic [wmmaf_pkg::LEN_W-1:0]   out_entries_used
);
  import wmmaf_pkg::*;

  // one request in flight: ready drops once a request is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after a request was taken");

  // a result taken while idle is not followed by another at once
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && in_ready) |=> !out_valid)
    else $error("result repeated after it was taken");

  a_entries_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entries_used != '0))
    else $error("result reports an empty window");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_filtered_value) &&
                                   $stable(out_alarm) && $stable(out_entries_used)))
    else $error("stalled result changed");

endmodule

bind windowed_median_mean_alarm_filter wmmaf_checker u_wmmaf_checker (.*);

// File: test/wmmaf_checker.sv
`timescale 1ns / 100ps

module wmmaf_scoreboard #(
  parameter int DEPTH = wmmaf_pkg::WINDOW_DEPTH_DEF,
  parameter int RAW_W = wmmaf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [RAW_W-1:0]                in_raw_sample,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [wmmaf_pkg::DATA_W-1:0]    out_filtered_value,
  input  logic                            out_alarm,
  input  logic [wmmaf_pkg::LEN_W-1:0]     out_entries_used,
  input  logic                            cfg_we,
  input  logic [wmmaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmmaf_pkg::CFG_W-1:0]     cfg_wdata,
  output int                              fail_count,
  output int                              outstanding,
  output int                              results_checked
);
  import wmmaf_pkg::*;

  localparam int SLOT_W = $clog2(DEPTH);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              alarm;
    logic [LEN_W-1:0]  used;
  } filter_result_t;

  filter_result_t awaited_results[$];
  filter_result_t oldest;

  logic [DATA_W-1:0]          cal_gain;
  logic signed [DATA_W-1:0]   cal_offset;
  logic [LEN_W-1:0]           win_len;
  logic                       median_sel;
  logic [DATA_W-1:0]          threshold;
  logic [DATA_W-1:0]          ring [DEPTH];
  logic [SLOT_W-1:0]          slot_next;
  logic [LEN_W-1:0]           filled;
  int                         mismatch_tally;
  int                         matched_tally;

  function automatic logic [DATA_W-1:0] calibrated(input logic [RAW_W-1:0] raw);
    logic [RAW_W+DATA_W-1:0] product;
    int level;
    product = raw * cal_gain;
    level = int'(product >> GAIN_FRAC) + int'(cal_offset);
    if (level < 0) return '0;
    if (level > 65535) return '1;
    return level[DATA_W-1:0];
  endfunction

  task automatic absorb_sample(input logic [RAW_W-1:0] raw);
    int len;
    int slot;
    int sum;
    int j;
    logic [DATA_W-1:0] sorted [DEPTH];
    logic [DATA_W-1:0] key;
    filter_result_t res;
    len = (win_len == 0) ? 1 : ((win_len > DEPTH) ? DEPTH : int'(win_len));
    slot = (slot_next < len) ? int'(slot_next) : 0;
    ring[slot] = calibrated(raw);
    slot_next = (slot + 1 >= len) ? '0 : SLOT_W'(slot + 1);
    if (filled > len) filled = LEN_W'(len);
    else if (filled < len) filled = filled + LEN_W'(1);
    if (median_sel) begin
      for (int i = 0; i < int'(filled); i++) begin
        key = ring[i];
        j = i;
        while (j > 0 && sorted[j-1] > key) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = key;
      end
      res.value = sorted[int'(filled) / 2];
    end else begin
      sum = 0;
      for (int i = 0; i < int'(filled); i++) sum += int'(ring[i]);
      res.value = DATA_W'(sum / int'(filled));
    end
    res.alarm = (res.value >= threshold);
    res.used = filled;
    awaited_results.push_back(res);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cal_gain = RST_CAL_GAIN;
      cal_offset = RST_CAL_OFFSET;
      win_len = RST_WINDOW_LEN;
      median_sel = RST_USE_MEDIAN;
      threshold = RST_ALARM_THR;
      foreach (ring[i]) ring[i] = '0;
      slot_next = '0;
      filled = '0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAL_GAIN:   cal_gain = cfg_wdata;
          CFG_CAL_OFFSET: cal_offset = cfg_wdata;
          CFG_WINDOW_LEN: win_len = cfg_wdata[LEN_W-1:0];
          CFG_USE_MEDIAN: median_sel = cfg_wdata[0];
          CFG_ALARM_THR:  threshold = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing awaited: filtered_value %0d alarm %0b entries_used %0d",
                 out_filtered_value, out_alarm, out_entries_used);
          mismatch_tally++;
        end else begin
          oldest = awaited_results.pop_front();
          matched_tally++;
          if (out_filtered_value !== oldest.value) begin
            $error("filtered_value: expected %0d, got %0d", oldest.value, out_filtered_value);
            mismatch_tally++;
          end
          if (out_alarm !== oldest.alarm) begin
            $error("alarm: expected %0b, got %0b", oldest.alarm, out_alarm);
            mismatch_tally++;
          end
          if (out_entries_used !== oldest.used) begin
            $error("entries_used: expected %0d, got %0d", oldest.used, out_entries_used);
            mismatch_tally++;
          end
        end
      end
      if (in_valid && in_ready) absorb_sample(in_raw_sample);
    end
    fail_count <= mismatch_tally;
    outstanding <= awaited_results.size();
    results_checked <= matched_tally;
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import wmmaf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_STALL = 400;
  localparam int PHASES = 15;
  localparam int PHASE_ITEMS = 50;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [11:0]          in_raw_sample;
  logic                 out_valid;
  logic                 out_ready;
  logic [DATA_W-1:0]    out_filtered_value;
  logic                 out_alarm;
  logic [LEN_W-1:0]     out_entries_used;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int fail_count;
  int outstanding;
  int results_checked;
  int send_idle_pct;
  int recv_idle_pct;
  int stalls_asked;
  int stalls_served;
  int sent_items;
  int settings_used;
  int quiet_cycles;

  windowed_median_mean_alarm_filter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_raw_sample      (in_raw_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value),
    .out_alarm          (out_alarm),
    .out_entries_used   (out_entries_used),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  wmmaf_scoreboard scoreboard (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_raw_sample      (in_raw_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value),
    .out_alarm          (out_alarm),
    .out_entries_used   (out_entries_used),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .outstanding        (outstanding),
    .results_checked    (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_served != stalls_asked) begin
        stalls_served++;
        out_ready <= 1'b0;
        repeat (LONG_STALL - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic [11:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_sample <= raw;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_filter(input logic [15:0] gain, offset, len_word, med_word, thr);
    write_reg(CFG_CAL_GAIN, gain);
    write_reg(CFG_CAL_OFFSET, offset);
    write_reg(CFG_WINDOW_LEN, len_word);
    write_reg(CFG_USE_MEDIAN, med_word);
    write_reg(CFG_ALARM_THR, thr);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  initial begin
    logic [11:0] raw;
    logic [11:0] prev_raw;
    logic [15:0] gain;
    logic [15:0] offset;
    logic [15:0] thr;
    logic [4:0]  len;
    logic        med;
    int          level;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_raw_sample <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_CAL_GAIN;
    cfg_wdata <= '0;
    send_idle_pct = 19;
    recv_idle_pct = 58;
    prev_raw = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: floor mean over a window of ten
    send_sample(12'd0);
    send_sample(12'hFFF);
    send_sample(12'd400);
    send_sample(12'd399);
    drain_results();
    // saturate high, full window, median
    program_filter(16'hFFFF, 16'h7FFF, 16'd16, 16'd1, 16'hFFFF);
    send_sample(12'hFFF);
    send_sample(12'd0);
    send_sample(12'd1);
    send_sample(12'h800);
    send_sample(12'h7FF);
    send_sample(12'hFFF);
    drain_results();
    // saturate low, alarm always set
    program_filter(16'h0000, 16'h8000, 16'd16, 16'd0, 16'h0000);
    send_sample(12'hFFF);
    send_sample(12'h555);
    send_sample(12'hAAA);
    drain_results();
    // ties in the median, ring wraps
    program_filter(16'd4096, 16'hFF9C, 16'd16, 16'd1, 16'd1000);
    send_sample(12'd50);
    send_sample(12'd2000);
    send_sample(12'd2000);
    send_sample(12'd2000);
    send_sample(12'd1100);
    drain_results();
    // shrink below the write position
    program_filter(16'd4096, 16'd0, 16'd2, 16'd0, 16'd2048);
    send_sample(12'd3000);
    send_sample(12'd1000);
    drain_results();
    // zero length acts as one
    program_filter(16'd8192, 16'd5, 16'd0, 16'd1, 16'd4000);
    send_sample(12'd2047);
    send_sample(12'd2048);
    drain_results();
    // over-long window, upper register bits set
    program_filter(16'd2048, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1024);
    send_sample(12'hFFF);
    send_sample(12'd1);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      if (phase == 5) begin
        send_idle_pct = 58;
        recv_idle_pct = 19;
      end else if (phase == 10) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: begin
          gain = 16'hFFFF;
          offset = 16'h7FFF;
          len = 5'd16;
          med = 1'b1;
        end
        1: begin
          gain = 16'h0000;
          offset = 16'h8000;
          len = 5'd1;
          med = 1'b0;
        end
        default: begin
          case ($urandom_range(3))
            0: gain = 16'd4096;
            1: gain = 16'($urandom_range(8192, 2048));
            default: gain = 16'($urandom);
          endcase
          offset = $urandom_range(1) ? 16'($urandom_range(400)) - 16'd200 : 16'($urandom);
          len = 5'($urandom_range(31));
          med = 1'($urandom_range(1));
        end
      endcase
      level = ((2048 * int'(gain)) >>> 12) + int'($signed(offset));
      level = level + int'($urandom_range(600)) - 300;
      if (level < 0) level = 0;
      if (level > 65535) level = 65535;
      thr = level[15:0];
      if (phase == 0) thr = 16'hFFFF;
      if (phase == 1) thr = 16'h0000;
      program_filter(gain, offset, (16'($urandom) & 16'hFFE0) | 16'(len),
                     (16'($urandom) & 16'hFFFE) | 16'(med), thr);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == 10 && (phase == 2 || phase == 7)) stalls_asked <= stalls_asked + 1;
        if (k == 25 && (phase == 4 || phase == 12)) drain_results();
        case ($urandom_range(7))
          0: raw = '0;
          1: raw = '1;
          2: raw = prev_raw;
          default: raw = 12'($urandom_range(4095));
        endcase
        send_sample(raw);
        prev_raw = raw;
      end
    end

    drain_results();
    repeat (64) @(posedge clk);
    $display("Checked %0d results from %0d samples over %0d register settings,",
             results_checked, sent_items, settings_used);
    $display("window lengths 0 to 31, mean and median, both clip limits and long output stalls.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/wmmaf_pkg.sv
rtl/windowed_median_mean_alarm_filter.sv
rtl/wmmaf_checker.sv
test/wmmaf_checker.sv
test/testbench.sv
